/* rtl/bsl_pkg.sv */
// Shared types, constants and character functions for the byte stream lexer.
package bsl_pkg;

	// Default saturation limit for positions and lengths.
	localparam int unsigned MAX_POSITION_DEF = 4096;

	// Depth of the queue between the front and back parts.
	localparam int unsigned QUEUE_DEPTH = 4;

	// Keyword trie: root node and the node that means no keyword is possible.
	localparam logic [4:0] TRIE_ROOT = 5'd0;
	localparam logic [4:0] TRIE_DEAD = 5'd31;

	// Token type codes as they appear on the result stream.
	typedef enum logic [2:0] {
		TOK_ID      = 3'd0,
		TOK_NUM     = 3'd1,
		TOK_OP      = 3'd2,
		TOK_KEYWORD = 3'd3,
		TOK_EOS     = 3'd4,
		TOK_INVALID = 3'd5
	} bsl_tok_t;

	// Scanner mode; the fourth code is treated as between tokens.
	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WORD = 2'd1,
		MODE_NUM  = 2'd2
	} bsl_mode_t;

	// Keyword index codes.
	localparam logic [1:0] KW_IF     = 2'd0;
	localparam logic [1:0] KW_ELSE   = 2'd1;
	localparam logic [1:0] KW_WHILE  = 2'd2;
	localparam logic [1:0] KW_RETURN = 2'd3;

	// One result record, last field in the lowest bits.
	typedef struct packed {
		logic [1:0]  keyword_index;
		logic [7:0]  single_char;
		logic [12:0] token_len;
		logic [11:0] start_pos;
		bsl_tok_t    token_type;
	} bsl_rec_t;

	// One queue entry: the results caused by one input beat.
	typedef struct packed {
		logic     two;
		bsl_rec_t rec1;
		bsl_rec_t rec0;
	} bsl_entry_t;

	function automatic logic is_alpha(logic [7:0] c);
		return (c inside {["a":"z"]}) || (c inside {["A":"Z"]});
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == " ") || (c inside {[8'd9:8'd13]});
	endfunction

	function automatic logic is_op(logic [7:0] c);
		return c inside {"+", "-", "*", "/", "="};
	endfunction

	// Next node of the keyword trie for if, else, while and return.
	function automatic logic [4:0] trie_next(logic [4:0] s, logic [7:0] c);
		logic [4:0] n;
		n = TRIE_DEAD;
		case (s)
			5'd0: begin
				if (c == "i") n = 5'd1;
				else if (c == "e") n = 5'd3;
				else if (c == "w") n = 5'd7;
				else if (c == "r") n = 5'd12;
			end
			5'd1:  if (c == "f") n = 5'd2;
			5'd3:  if (c == "l") n = 5'd4;
			5'd4:  if (c == "s") n = 5'd5;
			5'd5:  if (c == "e") n = 5'd6;
			5'd7:  if (c == "h") n = 5'd8;
			5'd8:  if (c == "i") n = 5'd9;
			5'd9:  if (c == "l") n = 5'd10;
			5'd10: if (c == "e") n = 5'd11;
			5'd12: if (c == "e") n = 5'd13;
			5'd13: if (c == "t") n = 5'd14;
			5'd14: if (c == "u") n = 5'd15;
			5'd15: if (c == "r") n = 5'd16;
			5'd16: if (c == "n") n = 5'd17;
			default: n = TRIE_DEAD;
		endcase
		return n;
	endfunction

	// Whether a trie node ends a keyword.
	function automatic logic trie_is_kw(logic [4:0] s);
		return (s == 5'd2) || (s == 5'd6) || (s == 5'd11) || (s == 5'd17);
	endfunction

	// Keyword index of a final trie node, zero elsewhere.
	function automatic logic [1:0] trie_kw_index(logic [4:0] s);
		logic [1:0] k;
		k = KW_IF;
		case (s)
			5'd6:    k = KW_ELSE;
			5'd11:   k = KW_WHILE;
			5'd17:   k = KW_RETURN;
			default: k = KW_IF;
		endcase
		return k;
	endfunction

endpackage

/* rtl/bsl_front.sv */
// Front part: takes byte beats, tracks the scanner state and forms result entries.
module bsl_front #(
	parameter int unsigned MAX_POSITION = bsl_pkg::MAX_POSITION_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] ch
	input  logic [0:0]          s_tuser,   // [0] op (end of string)
	input  logic                q_ready,
	output logic                push,
	output bsl_pkg::bsl_entry_t entry
);
	import bsl_pkg::*;

	localparam int unsigned PW = $clog2(MAX_POSITION);
	localparam int unsigned LW = $clog2(MAX_POSITION + 1);
	localparam logic [LW-1:0] POS_LIMIT   = LW'(MAX_POSITION);
	localparam logic [LW-1:0] START_LIMIT = LW'(MAX_POSITION - 1);

	bsl_mode_t   mode_q, mode_d;
	logic [PW-1:0] start_q, start_d;
	logic [LW-1:0] len_q, len_d;
	logic [4:0]  trie_q, trie_d;
	logic [LW-1:0] pos_q, pos_d;

	logic        fire;
	logic        op;
	logic [7:0]  ch;
	logic [LW-1:0] pos_sat;
	logic [LW-1:0] len_inc;
	logic        in_word, in_num, cont_word, cont_num;
	logic        has_flush, has_second;
	bsl_rec_t    flush_rec, second_rec;
	logic [31:0] start_q_wide, pos_sat_wide, len_q_wide;

	assign s_tready = q_ready;
	assign fire     = s_tvalid && s_tready;
	assign op       = s_tuser[0];
	assign ch       = s_tdata;

	assign pos_sat = (pos_q > START_LIMIT) ? START_LIMIT : pos_q;
	assign len_inc = (len_q < POS_LIMIT) ? len_q + LW'(1) : len_q;

	assign in_word   = (mode_q == MODE_WORD);
	assign in_num    = (mode_q == MODE_NUM);
	assign cont_word = !op && in_word && (is_alpha(ch) || is_digit(ch));
	assign cont_num  = !op && in_num && is_digit(ch);
	assign has_flush = (in_word || in_num) && !cont_word && !cont_num;

	// Resize the internal position and length values to the field widths.
	assign start_q_wide = 32'(start_q);
	assign pos_sat_wide = 32'(pos_sat);
	assign len_q_wide   = 32'(len_q);

	// Next scanner state.
	always_comb begin
		mode_d  = mode_q;
		start_d = start_q;
		len_d   = len_q;
		trie_d  = trie_q;
		pos_d   = (pos_q < POS_LIMIT) ? pos_q + LW'(1) : pos_q;
		if (op) begin
			mode_d  = MODE_IDLE;
			start_d = '0;
			len_d   = '0;
			trie_d  = TRIE_ROOT;
			pos_d   = '0;
		end else if (cont_word) begin
			len_d  = len_inc;
			trie_d = (trie_q != TRIE_DEAD) ? trie_next(trie_q, ch) : trie_q;
		end else if (cont_num) begin
			len_d = len_inc;
		end else begin
			mode_d = MODE_IDLE;
			len_d  = '0;
			trie_d = TRIE_ROOT;
			if (is_alpha(ch)) begin
				mode_d  = MODE_WORD;
				start_d = PW'(pos_sat);
				len_d   = LW'(1);
				trie_d  = trie_next(TRIE_ROOT, ch);
			end else if (is_digit(ch)) begin
				mode_d  = MODE_NUM;
				start_d = PW'(pos_sat);
				len_d   = LW'(1);
			end
		end
	end

	// Result records: the pending token first, then the beat's own token.
	always_comb begin
		flush_rec               = '0;
		flush_rec.start_pos     = start_q_wide[11:0];
		flush_rec.token_len     = len_q_wide[12:0];
		if (in_num) begin
			flush_rec.token_type = TOK_NUM;
		end else if (trie_is_kw(trie_q)) begin
			flush_rec.token_type    = TOK_KEYWORD;
			flush_rec.keyword_index = trie_kw_index(trie_q);
		end else begin
			flush_rec.token_type = TOK_ID;
		end

		second_rec           = '0;
		second_rec.start_pos = pos_sat_wide[11:0];
		has_second           = 1'b0;
		if (op) begin
			has_second            = 1'b1;
			second_rec.token_type = TOK_EOS;
		end else if (!cont_word && !cont_num && !is_alpha(ch) && !is_digit(ch)
				&& !is_space(ch)) begin
			has_second             = 1'b1;
			second_rec.token_type  = is_op(ch) ? TOK_OP : TOK_INVALID;
			second_rec.token_len   = 13'd1;
			second_rec.single_char = ch;
		end
	end

	// Pack the entry; an entry is pushed only when the beat gives a result.
	always_comb begin
		entry.two  = has_flush && has_second;
		entry.rec0 = has_flush ? flush_rec : second_rec;
		entry.rec1 = second_rec;
		push       = fire && (has_flush || has_second);
	end

	// Scanner state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			start_q <= '0;
			len_q   <= '0;
			trie_q  <= TRIE_ROOT;
			pos_q   <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			start_q <= start_d;
			len_q   <= len_d;
			trie_q  <= trie_d;
			pos_q   <= pos_d;
		end
	end

	// The end mark returns the scanner to the start of a new string.
	a_eos_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op |=> mode_q == MODE_IDLE && pos_q == '0 && len_q == '0)
		else $error("scanner state not cleared after end mark");

	// Only a word carries a trie node other than the root.
	a_trie_root: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_WORD |-> trie_q == TRIE_ROOT)
		else $error("trie node left outside a word");

	// Length never passes the saturation limit.
	a_len_sat: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= POS_LIMIT && pos_q <= POS_LIMIT)
		else $error("length or position beyond limit");

endmodule

/* rtl/bsl_queue.sv */
// Short queue of result entries between the front and back parts.
module bsl_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bsl_pkg::bsl_entry_t wr_entry,
	output logic                wr_ready,
	input  logic                pop,
	output logic                rd_valid,
	output bsl_pkg::bsl_entry_t rd_entry
);
	import bsl_pkg::*;

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	bsl_entry_t    slot_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign wr_ready = (count_q != CW'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_entry = slot_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// The fill count stays within the depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue fill count out of range");

	// Nothing is taken from an empty queue nor written to a full one.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !rd_valid) && !(push && !wr_ready))
		else $error("queue overflow or underflow");

	// The write pointer leads the read pointer by the fill count; checked here for the empty queue.
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with fill count");

endmodule

/* rtl/bsl_back.sv */
// Back part: splits queue entries into result beats through an output register.
module bsl_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_valid,
	input  bsl_pkg::bsl_entry_t rd_entry,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [39:0]         m_tdata,  // [2:0] token_type, [14:3] start_pos,
	                                      // [27:15] token_len, [35:28] single_char,
	                                      // [37:36] keyword_index, [39:38] zero
	output logic                m_tlast
);
	import bsl_pkg::*;

	logic     out_valid_q;
	bsl_rec_t out_rec_q;
	logic     out_last_q;
	logic     sel_q;
	logic     load;
	logic     take_last;

	assign load      = !out_valid_q || m_tready;
	assign take_last = sel_q || !rd_entry.two;
	assign pop       = load && rd_valid && take_last;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_rec_q};
	assign m_tlast  = out_last_q;

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load && rd_valid) begin
			out_rec_q  <= sel_q ? rd_entry.rec1 : rd_entry.rec0;
			out_last_q <= take_last;
		end
	end

	// Output valid and second-record select.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else if (load) begin
			out_valid_q <= rd_valid;
			if (rd_valid) begin
				sel_q <= !take_last;
			end
		end
	end

	// The second record is only selected for an entry that holds two.
	a_sel_two: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> rd_valid && rd_entry.two)
		else $error("second record selected without a two-record entry");

	// Once the first record of a pair is loaded, the second one is selected next.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		load && rd_valid && !take_last |=> sel_q && rd_entry.two)
		else $error("pair split out of order");

	// Every entry ends with a beat marked last.
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q && out_last_q)
		else $error("entry popped without a last beat");

endmodule

/* rtl/byte_stream_lexer_unit.sv */
// Top level of the byte stream lexer: front, queue and back joined.
//
//  Channel   Direction  tdata              tuser        tlast
//  s_*       in         ch (8)             op (1)       -
//  m_*       out        token record (40)  -            last result of the beat
//
//  One input beat is taken each cycle while the entry queue has room; a beat's
//  results pass through the queue and then the output register.
//  A beat that gives two results (token plus terminator, or token plus end
//  mark) hands them to the output register one after the other.
//  The output register is the only link to the downstream side; the front
//  stalls only when the queue of QUEUE_DEPTH entries is full.
//  Reset is asynchronous and clears the scanner, the queue and the output.
module byte_stream_lexer_unit #(
	parameter int unsigned MAX_POSITION = bsl_pkg::MAX_POSITION_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic [0:0]  s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [2:0] token_type, [14:3] start_pos,
	                               // [27:15] token_len, [35:28] single_char,
	                               // [37:36] keyword_index, [39:38] zero
	output logic        m_tlast
);
	import bsl_pkg::*;

	logic       q_ready, push, pop, rd_valid;
	bsl_entry_t wr_entry, rd_entry;

	// Classification and scanner state.
	bsl_front #(
		.MAX_POSITION(MAX_POSITION)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_ready (q_ready),
		.push    (push),
		.entry   (wr_entry)
	);

	// Entry queue.
	bsl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(wr_entry),
		.wr_ready(q_ready),
		.pop     (pop),
		.rd_valid(rd_valid),
		.rd_entry(rd_entry)
	);

	// Result beats.
	bsl_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_valid(rd_valid),
		.rd_entry(rd_entry),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the byte stream lexer, with its own token predictor.
module testbench;
	import bsl_pkg::*;

	localparam int unsigned POS_LIMIT      = MAX_POSITION_DEF;
	localparam int unsigned RANDOM_BEATS   = 1050;
	localparam int unsigned LONG_RUN       = 150;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 16;

	// One expected result: the token record and the end-of-beat flag.
	typedef struct packed {
		logic     last;
		bsl_rec_t rec;
	} token_expect_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic [0:0]  s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	// Set during stretches where neither side may idle.
	logic        calm = 1'b0;

	token_expect_t expected_tokens[$];
	bsl_rec_t      beat_tokens[$];
	int unsigned   mismatches = 0;
	int unsigned   beats_sent = 0;
	int unsigned   quiet_cycles = 0;
	token_expect_t want;
	bsl_rec_t      got;

	// Predictor state.
	bsl_mode_t   lex_mode = MODE_IDLE;
	int unsigned lex_pos = 0;
	int unsigned tok_len = 0;
	logic [11:0] tok_start = '0;
	logic [47:0] word_tail = '0;
	int unsigned word_chars = 0;

	string keyword_text[4] = '{"if", "else", "while", "return"};

	byte_stream_lexer_unit #(.MAX_POSITION(POS_LIMIT)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Character classes of the lexer.
	function automatic logic letter_byte(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic numeral_byte(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic blank_byte(logic [7:0] c);
		return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic operator_byte(logic [7:0] c);
		return c == "+" || c == "-" || c == "*" || c == "/" || c == "=";
	endfunction

	function automatic logic [11:0] clamp_pos(int unsigned p);
		return (p > POS_LIMIT - 1) ? 12'(POS_LIMIT - 1) : 12'(p);
	endfunction

	// A token that starts at the current position and carries its own byte.
	function automatic void add_here(bsl_tok_t kind, int unsigned len, logic [7:0] c);
		bsl_rec_t r;
		r = '0;
		r.token_type  = kind;
		r.start_pos   = clamp_pos(lex_pos);
		r.token_len   = 13'(len);
		r.single_char = c;
		beat_tokens.push_back(r);
	endfunction

	// Report the pending word or number, if any, and go back between tokens.
	function automatic void close_token();
		bsl_rec_t r;
		r = '0;
		r.start_pos = tok_start;
		r.token_len = 13'(tok_len);
		if (lex_mode == MODE_WORD) begin
			r.token_type = TOK_ID;
			if (word_chars == 2 && word_tail[15:0] == "if") begin
				r.token_type = TOK_KEYWORD;
				r.keyword_index = KW_IF;
			end else if (word_chars == 4 && word_tail[31:0] == "else") begin
				r.token_type = TOK_KEYWORD;
				r.keyword_index = KW_ELSE;
			end else if (word_chars == 5 && word_tail[39:0] == "while") begin
				r.token_type = TOK_KEYWORD;
				r.keyword_index = KW_WHILE;
			end else if (word_chars == 6 && word_tail == "return") begin
				r.token_type = TOK_KEYWORD;
				r.keyword_index = KW_RETURN;
			end
			beat_tokens.push_back(r);
		end else if (lex_mode == MODE_NUM) begin
			r.token_type = TOK_NUM;
			beat_tokens.push_back(r);
		end
		lex_mode   = MODE_IDLE;
		tok_len    = 0;
		word_chars = 0;
		word_tail  = '0;
	endfunction

	function automatic void open_token(bsl_mode_t mode, logic [7:0] c);
		lex_mode   = mode;
		tok_start  = clamp_pos(lex_pos);
		tok_len    = 1;
		word_chars = 1;
		word_tail  = {40'b0, c};
	endfunction

	// Work out the tokens that one accepted beat gives and queue them.
	function automatic void lex_byte(logic op_bit, logic [7:0] c);
		beat_tokens.delete();
		if (op_bit) begin
			close_token();
			add_here(TOK_EOS, 0, 8'h00);
			lex_pos   = 0;
			tok_start = '0;
		end else begin
			if (lex_mode == MODE_WORD && (letter_byte(c) || numeral_byte(c))) begin
				if (tok_len < POS_LIMIT) tok_len++;
				// Seven characters are enough to rule out every keyword.
				if (word_chars < 7) begin
					word_tail = {word_tail[39:0], c};
					word_chars++;
				end
			end else if (lex_mode == MODE_NUM && numeral_byte(c)) begin
				if (tok_len < POS_LIMIT) tok_len++;
			end else begin
				close_token();
				if (letter_byte(c)) open_token(MODE_WORD, c);
				else if (numeral_byte(c)) open_token(MODE_NUM, c);
				else if (blank_byte(c)) ;
				else if (operator_byte(c)) add_here(TOK_OP, 1, c);
				else add_here(TOK_INVALID, 1, c);
			end
			if (lex_pos < POS_LIMIT) lex_pos++;
		end
		foreach (beat_tokens[i])
			expected_tokens.push_back(token_expect_t'{last: (i == beat_tokens.size() - 1),
				rec: beat_tokens[i]});
	endfunction

	// Offer one beat, with a random idle gap in front, and predict once taken.
	task automatic send_beat(input logic op_bit, input logic [7:0] c);
		while (!calm && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op_bit;
		s_tdata  <= c;
		do @(posedge clk); while (!s_tready);
		lex_byte(op_bit, c);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i]);
	endtask

	function automatic logic [7:0] random_letter();
		logic [7:0] c;
		c = 8'(8'h61 + $urandom_range(25));
		if ($urandom_range(1)) c = c - 8'h20;
		return c;
	endfunction

	function automatic logic [7:0] random_alnum();
		if ($urandom_range(3) == 0) return 8'(8'h30 + $urandom_range(9));
		return random_letter();
	endfunction

	// Every keyword and operator, each ending its word, then high and zero bytes.
	task automatic test_keywords_and_operators();
		send_text("if+else/while-return*7=x");
		send_beat(1'b0, 8'hFF);
		send_beat(1'b0, 8'h00);
		send_beat(1'b1, 8'hA5);
	endtask

	// A number running into a word, whitespace, and a number flushed by the end mark.
	task automatic test_number_word_boundary();
		send_text("12ab 3");
		send_beat(1'b1, 8'hFF);
	endtask

	// A long word and a long number back to back, with no idling on either side.
	task automatic test_long_tokens();
		calm = 1'b1;
		send_beat(1'b0, random_letter());
		repeat (LONG_RUN) send_beat(1'b0, random_alnum());
		send_beat(1'b0, "+");
		repeat (LONG_RUN) send_beat(1'b0, 8'(8'h30 + $urandom_range(9)));
		send_text(" if");
		send_beat(1'b1, 8'h00);
		calm = 1'b0;
	endtask

	// Mostly well-formed text with random content, with noise and end marks mixed in.
	task automatic test_random_text();
		int unsigned first;
		int unsigned kind;
		int unsigned k;
		int unsigned n;
		string kw;
		first = beats_sent;
		while (beats_sent - first < RANDOM_BEATS) begin
			calm = (beats_sent - first >= 500) && (beats_sent - first < 700);
			kind = $urandom_range(99);
			if (kind < 20) begin
				// A keyword, a prefix of one, or one with more characters after it.
				kw = keyword_text[$urandom_range(3)];
				k = $urandom_range(2);
				n = (k == 1) ? kw.len() - 1 : kw.len();
				for (int i = 0; i < n; i++) send_beat(1'b0, kw[i]);
				if (k == 2) send_beat(1'b0, random_alnum());
			end else if (kind < 38) begin
				n = $urandom_range(8);
				send_beat(1'b0, random_letter());
				for (int i = 1; i < n; i++) send_beat(1'b0, random_alnum());
			end else if (kind < 53) begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) send_beat(1'b0, 8'(8'h30 + $urandom_range(9)));
			end else if (kind < 68) begin
				case ($urandom_range(4))
					0: send_beat(1'b0, "+");
					1: send_beat(1'b0, "-");
					2: send_beat(1'b0, "*");
					3: send_beat(1'b0, "/");
					default: send_beat(1'b0, "=");
				endcase
			end else if (kind < 84) begin
				k = $urandom_range(5);
				send_beat(1'b0, (k == 0) ? 8'h20 : 8'(8 + k));
			end else if (kind < 93) begin
				send_beat(1'b0, 8'($urandom_range(255)));
			end else begin
				send_beat(1'b1, 8'($urandom_range(255)));
			end
		end
		calm = 1'b0;
		send_beat(1'b1, 8'($urandom_range(255)));
	endtask

	// Downstream side: stall at random unless in a calm stretch.
	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 15);
	end

	// Compare each result beat with the oldest expectation; watch for a hang.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got = bsl_rec_t'(m_tdata[37:0]);
			if (expected_tokens.size() == 0) begin
				$error("unexpected result beat: tdata %h tlast %b", m_tdata, m_tlast);
				mismatches++;
			end else begin
				want = expected_tokens.pop_front();
				if (got.token_type !== want.rec.token_type) begin
					$error("token_type: expected %0d, got %0d",
						want.rec.token_type, got.token_type);
					mismatches++;
				end
				if (got.start_pos !== want.rec.start_pos) begin
					$error("start_pos: expected %0d, got %0d",
						want.rec.start_pos, got.start_pos);
					mismatches++;
				end
				if (got.token_len !== want.rec.token_len) begin
					$error("token_len: expected %0d, got %0d",
						want.rec.token_len, got.token_len);
					mismatches++;
				end
				if (got.single_char !== want.rec.single_char) begin
					$error("single_char: expected %0d, got %0d",
						want.rec.single_char, got.single_char);
					mismatches++;
				end
				if (got.keyword_index !== want.rec.keyword_index) begin
					$error("keyword_index: expected %0d, got %0d",
						want.rec.keyword_index, got.keyword_index);
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					mismatches++;
				end
				if (m_tdata[39:38] !== 2'b00) begin
					$error("padding: expected 0, got %0d", m_tdata[39:38]);
					mismatches++;
				end
			end
		end

		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL byte_stream_lexer_unit");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_keywords_and_operators();
		test_number_word_boundary();
		test_long_tokens();
		test_random_text();
		s_tvalid <= 1'b0;

		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS byte_stream_lexer_unit");
		end else begin
			$display("FAIL byte_stream_lexer_unit");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/bsl_pkg.sv
rtl/bsl_front.sv
rtl/bsl_queue.sv
rtl/bsl_back.sv
rtl/byte_stream_lexer_unit.sv
verif/testbench.sv
